/* hw/rtl/bah_pkg.sv */
package bah_pkg;

   // Histogram geometry and counter width.
   localparam int PT_BIN_COUNT = 19;
   localparam int Y_BIN_COUNT  = 10;
   localparam int COUNT_BITS   = 32;
   localparam int BIN_TOTAL    = PT_BIN_COUNT * Y_BIN_COUNT;
   localparam int PT_BIN_BITS  = (PT_BIN_COUNT > 1) ? $clog2(PT_BIN_COUNT) : 1;
   localparam int Y_BIN_BITS   = (Y_BIN_COUNT > 1) ? $clog2(Y_BIN_COUNT) : 1;
   localparam int BIN_BITS     = (BIN_TOTAL > 1) ? $clog2(BIN_TOTAL) : 1;

   // Configuration register port.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MUON_PT_MINIMUM = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MUON_ETA_LIMIT  = 2'd1;
   localparam logic [15:0] MUON_PT_MINIMUM_RESET = 16'd896;
   localparam logic [14:0] MUON_ETA_LIMIT_RESET  = 15'd9830;

   // Item function codes.
   localparam logic FUNC_RECORD = 1'b0;
   localparam logic FUNC_READ   = 1'b1;

   // Bin edges: momentum in 1/256 GeV, rapidity in 1/4096 units.
   localparam logic [15:0] PT_EDGE [PT_BIN_COUNT+1] = '{
      16'd2560, 16'd2816, 16'd3072, 16'd3328, 16'd3584, 16'd3840, 16'd4096,
      16'd4352, 16'd4608, 16'd4864, 16'd5120, 16'd5376, 16'd5632, 16'd5888,
      16'd6144, 16'd6656, 16'd7168, 16'd7680, 16'd8960, 16'd10240};

   localparam logic signed [15:0] Y_EDGE [Y_BIN_COUNT+1] = '{
      -16'sd8192, -16'sd7168, -16'sd6144, -16'sd4096, -16'sd2048, 16'sd0,
      16'sd2048, 16'sd4096, 16'sd6144, 16'sd7168, 16'sd8192};

   typedef struct packed {
      logic               func;
      logic [15:0]        cand_pt;
      logic signed [15:0] cand_rapidity;
      logic [15:0]        first_mu_pt;
      logic [15:0]        second_mu_pt;
      logic signed [15:0] first_mu_eta;
      logic signed [15:0] second_mu_eta;
      logic               muons_present;
      logic [7:0]         read_bin;
   } req_type;

   typedef struct packed {
      logic        in_fiducial;
      logic        passed_cuts;
      logic        was_malformed;
      logic [7:0]  bin_index;
      logic [31:0] bin_fiducial_count;
      logic [31:0] bin_accepted_count;
      logic [31:0] sum_fiducial;
      logic [31:0] sum_accepted;
      logic [31:0] sum_malformed;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOCATE,
      ST_FETCH,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic locate;
      logic clear;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } sts_type;

   function automatic logic pt_in_range(input logic [15:0] v);
      return (v >= PT_EDGE[0]) && (v < PT_EDGE[PT_BIN_COUNT]);
   endfunction

   function automatic logic [PT_BIN_BITS-1:0] pt_bin_of(input logic [15:0] v);
      logic [PT_BIN_COUNT:0]  ge;
      logic [PT_BIN_BITS-1:0] bin;
      bin = '0;
      for (int k = 0; k <= PT_BIN_COUNT; k++) begin
         ge[k] = (v >= PT_EDGE[k]);
      end
      for (int k = 0; k < PT_BIN_COUNT; k++) begin
         if (ge[k] && !ge[k+1]) begin
            bin = bin | PT_BIN_BITS'(k);
         end
      end
      return bin;
   endfunction

   function automatic logic y_in_range(input logic signed [15:0] v);
      return (v >= Y_EDGE[0]) && (v < Y_EDGE[Y_BIN_COUNT]);
   endfunction

   function automatic logic [Y_BIN_BITS-1:0] y_bin_of(input logic signed [15:0] v);
      logic [Y_BIN_COUNT:0]  ge;
      logic [Y_BIN_BITS-1:0] bin;
      bin = '0;
      for (int k = 0; k <= Y_BIN_COUNT; k++) begin
         ge[k] = (v >= Y_EDGE[k]);
      end
      for (int k = 0; k < Y_BIN_COUNT; k++) begin
         if (ge[k] && !ge[k+1]) begin
            bin = bin | Y_BIN_BITS'(k);
         end
      end
      return bin;
   endfunction

   // A muon passes when its momentum exceeds the minimum and its |eta| is
   // below the limit. The most negative eta has magnitude 32768 and fails.
   function automatic logic muon_passes(input logic [15:0] pt,
                                        input logic signed [15:0] eta,
                                        input logic [15:0] pt_min,
                                        input logic [14:0] eta_lim);
      logic [15:0] mag;
      mag = eta[15] ? 16'(-eta) : 16'(eta);
      return (pt > pt_min) && (mag < {1'b0, eta_lim});
   endfunction

   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      return (&c) ? c : c + COUNT_BITS'(1);
   endfunction

endpackage

/* hw/rtl/bah_ram.sv */
module bah_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 190
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bah_ctrl.sv */
module bah_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bah_pkg::sts_type sts,
   output bah_pkg::cmd_type cmd
);

   bah_pkg::state_type state_ff;
   bah_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bah_pkg::ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = bah_pkg::ST_IDLE;
            end
         end
         bah_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bah_pkg::ST_LOCATE;
            end
         end
         bah_pkg::ST_LOCATE: begin
            state_in = bah_pkg::ST_FETCH;
         end
         bah_pkg::ST_FETCH: begin
            state_in = bah_pkg::ST_COMMIT;
         end
         bah_pkg::ST_COMMIT: begin
            if (sts.out_free) begin
               state_in = bah_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bah_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bah_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         bah_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         bah_pkg::ST_LOCATE: begin
            cmd.locate = 1'b1;
         end
         bah_pkg::ST_FETCH: begin
            cmd = '0;
         end
         bah_pkg::ST_COMMIT: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bah_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/bah_datapath.sv */
module bah_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bah_pkg::cmd_type                     cmd,
   output bah_pkg::sts_type                     sts,
   input  bah_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bah_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [bah_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bah_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int BB = bah_pkg::BIN_BITS;
   localparam int CB = bah_pkg::COUNT_BITS;

   // Configuration registers.
   logic [15:0] pt_min_ff, pt_min_in;
   logic [14:0] eta_lim_ff, eta_lim_in;

   always_comb begin
      pt_min_in  = pt_min_ff;
      eta_lim_in = eta_lim_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            bah_pkg::CSR_MUON_PT_MINIMUM: pt_min_in  = csr_data[15:0];
            bah_pkg::CSR_MUON_ETA_LIMIT:  eta_lim_in = csr_data[14:0];
            default: begin
               pt_min_in  = pt_min_ff;
               eta_lim_in = eta_lim_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_min_ff  <= bah_pkg::MUON_PT_MINIMUM_RESET;
         eta_lim_ff <= bah_pkg::MUON_ETA_LIMIT_RESET;
      end else begin
         pt_min_ff  <= pt_min_in;
         eta_lim_ff <= eta_lim_in;
      end
   end

   // Captured item.
   bah_pkg::req_type req_ff, req_in;

   assign req_in = cmd.capture ? req_payload : req_ff;

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   // Bin lookup and cut evaluation.
   logic          is_record;
   logic          cand_hit;
   logic          read_hit;
   logic [BB-1:0] flat_bin;
   logic          mu_ok;
   logic [BB-1:0] bin_ff, bin_in;
   logic          hit_ff, hit_in;
   logic          fid_ff, fid_in;
   logic          pass_ff, pass_in;
   logic          bad_ff, bad_in;

   always_comb begin
      is_record = (req_ff.func == bah_pkg::FUNC_RECORD);
      cand_hit  = bah_pkg::pt_in_range(req_ff.cand_pt)
                  && bah_pkg::y_in_range(req_ff.cand_rapidity);
      flat_bin  = BB'(BB'(bah_pkg::y_bin_of(req_ff.cand_rapidity))
                      * BB'(bah_pkg::PT_BIN_COUNT))
                  + BB'(bah_pkg::pt_bin_of(req_ff.cand_pt));
      read_hit  = (int'(req_ff.read_bin) < bah_pkg::BIN_TOTAL);
      mu_ok     = bah_pkg::muon_passes(req_ff.first_mu_pt, req_ff.first_mu_eta,
                                       pt_min_ff, eta_lim_ff)
                  && bah_pkg::muon_passes(req_ff.second_mu_pt, req_ff.second_mu_eta,
                                          pt_min_ff, eta_lim_ff);
      bin_in  = bin_ff;
      hit_in  = hit_ff;
      fid_in  = fid_ff;
      pass_in = pass_ff;
      bad_in  = bad_ff;
      if (cmd.locate) begin
         if (is_record) begin
            hit_in = cand_hit;
            bin_in = cand_hit ? flat_bin : '0;
         end else begin
            hit_in = read_hit;
            bin_in = read_hit ? BB'(req_ff.read_bin) : '0;
         end
         fid_in  = is_record && cand_hit;
         bad_in  = is_record && cand_hit && !req_ff.muons_present;
         pass_in = is_record && cand_hit && req_ff.muons_present && mu_ok;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      hit_ff  <= hit_in;
      fid_ff  <= fid_in;
      pass_ff <= pass_in;
      bad_ff  <= bad_in;
   end

   // Clearing sweep after reset.
   logic [BB-1:0] clear_addr_ff, clear_addr_in;

   assign clear_addr_in  = cmd.clear ? clear_addr_ff + BB'(1) : clear_addr_ff;
   assign sts.clear_last = (clear_addr_ff == BB'(bah_pkg::BIN_TOTAL - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
      end else begin
         clear_addr_ff <= clear_addr_in;
      end
   end

   // Histogram stores.
   logic          ram_we;
   logic [BB-1:0] ram_waddr;
   logic [CB-1:0] fid_old, acc_old;
   logic [CB-1:0] fid_new, acc_new;
   logic [CB-1:0] fid_wdata, acc_wdata;

   always_comb begin
      fid_new   = fid_ff ? bah_pkg::bump(fid_old) : fid_old;
      acc_new   = pass_ff ? bah_pkg::bump(acc_old) : acc_old;
      ram_we    = cmd.clear || (cmd.commit && fid_ff);
      ram_waddr = cmd.clear ? clear_addr_ff : bin_ff;
      fid_wdata = cmd.clear ? '0 : fid_new;
      acc_wdata = cmd.clear ? '0 : acc_new;
   end

   bah_ram #(
      .WIDTH (CB),
      .DEPTH (bah_pkg::BIN_TOTAL)
   ) u_fid_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (fid_wdata),
      .rd_addr (bin_ff),
      .rd_data (fid_old)
   );

   bah_ram #(
      .WIDTH (CB),
      .DEPTH (bah_pkg::BIN_TOTAL)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (acc_wdata),
      .rd_addr (bin_ff),
      .rd_data (acc_old)
   );

   // Running totals.
   logic [CB-1:0] fid_total_ff, fid_total_in;
   logic [CB-1:0] acc_total_ff, acc_total_in;
   logic [CB-1:0] bad_total_ff, bad_total_in;
   logic [CB-1:0] fid_total_nx, acc_total_nx, bad_total_nx;

   always_comb begin
      fid_total_nx = fid_ff ? bah_pkg::bump(fid_total_ff) : fid_total_ff;
      acc_total_nx = pass_ff ? bah_pkg::bump(acc_total_ff) : acc_total_ff;
      bad_total_nx = bad_ff ? bah_pkg::bump(bad_total_ff) : bad_total_ff;
      fid_total_in = cmd.commit ? fid_total_nx : fid_total_ff;
      acc_total_in = cmd.commit ? acc_total_nx : acc_total_ff;
      bad_total_in = cmd.commit ? bad_total_nx : bad_total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fid_total_ff <= '0;
         acc_total_ff <= '0;
         bad_total_ff <= '0;
      end else begin
         fid_total_ff <= fid_total_in;
         acc_total_ff <= acc_total_in;
         bad_total_ff <= bad_total_in;
      end
   end

   // Output register.
   bah_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.commit) begin
         rsp_in.in_fiducial        = fid_ff;
         rsp_in.passed_cuts        = pass_ff;
         rsp_in.was_malformed      = bad_ff;
         rsp_in.bin_index          = 8'(bin_ff);
         rsp_in.bin_fiducial_count = hit_ff ? 32'(fid_new) : '0;
         rsp_in.bin_accepted_count = hit_ff ? 32'(acc_new) : '0;
         rsp_in.sum_fiducial       = 32'(fid_total_nx);
         rsp_in.sum_accepted       = 32'(acc_total_nx);
         rsp_in.sum_malformed      = 32'(bad_total_nx);
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;

endmodule

/* hw/rtl/binned_acceptance_histogrammer.sv */
// Two-dimensional momentum by rapidity histogrammer with a two-muon acceptance cut.
// The req channel carries one item per transfer: a record item bins a candidate
// into one of 190 variable-width bins and bumps that bin's fiducial count, and its
// accepted count when both muons pass the cuts; a read item returns one bin's counts.
// The rsp channel returns exactly one result per item, with the bin's counts after
// the update and the three running totals. All counters saturate at their maximum.
// The csr port writes the muon momentum minimum (index 0) and |eta| limit (index 1)
// in the cycle its write enable is high; write only while no item is in flight.
// An item walks through capture, bin lookup, the registered histogram read and the commit
// write, and a new item is taken only after that commit, which waits while the output
// register is full; the single read-modify-write pass over the histogram memories
// sets that limit.
// After reset the block sweeps zeros through both histogram memories, one bin per
// cycle, with req_ready low. The totals clear and the cut registers return to their
// reset values at once.
// The result sits in an output register: a new item is taken while the previous
// result still waits, and when the receiver stalls the commit of the next item is
// held until the output register is free, so no result is lost or reordered.
module binned_acceptance_histogrammer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bah_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bah_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [bah_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bah_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   // Commands from the sequencer and status back from the datapath.
   bah_pkg::cmd_type cmd;
   bah_pkg::sts_type sts;

   bah_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bah_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

`ifndef ASSERT_OFF
   // No item may be taken while the histogram memories are still being cleared.
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_ready)
      else $error("input accepted during clearing sweep");

   // A commit only loads the output register once the previous result has left.
   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("commit overwrote a pending result");

   // One item at a time: right after an input transfer the block is busy.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is in flight");

   // The clearing sweep and a histogram update never write in the same cycle.
   a_clear_commit_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear && cmd.commit))
      else $error("clear and commit collide on histogram write port");
`endif

endmodule
